// File: rtl/tfc_pkg.sv
package tfc_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARITH,
    ST_CPREP,
    ST_CITER,
    ST_CDONE,
    ST_CLASS
  } state_t;

  // posture codes
  typedef enum logic [2:0] {
    POS_STANDING   = 3'd0,
    POS_FALL_SIDE  = 3'd1,
    POS_LIE_SIDE   = 3'd2,
    POS_FALL_BACK  = 3'd3,
    POS_LIE_BACK   = 3'd4,
    POS_FALL_FRONT = 3'd5,
    POS_LIE_FRONT  = 3'd6
  } posture_t;

  // configuration register indexes
  localparam logic [2:0] REG_FILTER_GAIN  = 3'd0;
  localparam logic [2:0] REG_STANDING_MAG = 3'd1;
  localparam logic [2:0] REG_TILT_MAG     = 3'd2;
  localparam logic [2:0] REG_FALLING_ANG  = 3'd3;
  localparam logic [2:0] REG_LYING_ANG    = 3'd4;
  localparam logic [2:0] REG_FALL_HOLD    = 3'd5;

  localparam int ACC_FRAC_BITS   = 8;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_SHIFT     = 16 - ANGLE_FRAC_BITS;
  localparam int FILT_EXTRA      = 8;
  localparam int CORDIC_STEPS    = 16;
  localparam int ACC_LIMIT_INT   = 10000;

  localparam logic signed [23:0] ACC_LIMIT = 24'(ACC_LIMIT_INT << ACC_FRAC_BITS);
  localparam logic signed [20:0] PI_Q16    = 21'sd205887;

  // arctangent of 2^-i in Q.16
  function automatic logic [15:0] atan_q16(input logic [3:0] idx);
    logic [15:0] v;
    unique case (idx)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/tilt_fall_classifier.sv
// from input transfer to out_tvalid: ARITH, a roll and then a pitch pass of the shared CORDIC
// stage (CPREP, CITER, CDONE), then CLASS; a pass with a zero y component skips its rotations,
// a stalled result holds the sequencer in CLASS, and a new sample is taken only in IDLE; the
// shared 33x33 multiplier takes 9 steps (filter, squared magnitude, thresholds)
// reset (rst_n low, synchronous): filter state, posture and fall time cleared,
// registers return to their defaults, no result pending
module tilt_fall_classifier (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // acc_x[22:0], acc_y[45:23], acc_z[68:46], axis_invalid[71:69], time_ms[103:72]
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // orientation[2:0], fallen[3], roll_angle[19:4], pitch_angle[35:20],
  // up_x[58:36], up_y[81:59], up_z[104:82], zero fill[111:105]
  output logic [111:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  // configuration
  logic [15:0] gain_r, stand_mag_r, tilt_mag_r, hold_r;
  logic [14:0] fall_ang_r, lie_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= 16'd3277;
      stand_mag_r <= 16'd1280;
      tilt_mag_r  <= 16'd1536;
      fall_ang_r  <= 15'd6554;
      lie_ang_r   <= 15'd9830;
      hold_r      <= 16'd3000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tfc_pkg::REG_FILTER_GAIN:  gain_r      <= cfg_wdata;
        tfc_pkg::REG_STANDING_MAG: stand_mag_r <= cfg_wdata;
        tfc_pkg::REG_TILT_MAG:     tilt_mag_r  <= cfg_wdata;
        tfc_pkg::REG_FALLING_ANG:  fall_ang_r  <= cfg_wdata[14:0];
        tfc_pkg::REG_LYING_ANG:    lie_ang_r   <= cfg_wdata[14:0];
        tfc_pkg::REG_FALL_HOLD:    hold_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tfc_pkg::state_t state_r, state_nxt;
  logic [3:0]  step_r;
  logic        pass_r;
  logic        in_xfer, out_free;

  assign in_tready = (state_r == tfc_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid || out_tready;

  // input sanitizing: negate x and y, zero invalid or out-of-range axes
  logic signed [23:0] nx, ny, nz;
  logic signed [22:0] sx, sy, sz;

  always_comb begin
    nx = -{in_tdata[22], in_tdata[22:0]};
    ny = -{in_tdata[45], in_tdata[45:23]};
    nz = {in_tdata[68], in_tdata[68:46]};
    sx = (in_tdata[69] || nx <= -tfc_pkg::ACC_LIMIT || nx >= tfc_pkg::ACC_LIMIT)
         ? '0 : nx[22:0];
    sy = (in_tdata[70] || ny <= -tfc_pkg::ACC_LIMIT || ny >= tfc_pkg::ACC_LIMIT)
         ? '0 : ny[22:0];
    sz = (in_tdata[71] || nz <= -tfc_pkg::ACC_LIMIT || nz >= tfc_pkg::ACC_LIMIT)
         ? '0 : nz[22:0];
  end

  logic signed [22:0] ax_r, ay_r, az_r;
  logic [31:0]        now_r;
  logic signed [31:0] fx_r, fy_r, fz_r;
  logic [63:0]        mag_r;
  logic               low_r, hi_r;
  logic signed [65:0] prod_r;

  // shared multiplier operand select
  logic signed [32:0] mul_a, mul_b, diff_a;
  logic signed [22:0] acc_sel;
  logic signed [31:0] f_sel;

  always_comb begin
    unique case (step_r)
      4'd1:    begin acc_sel = ay_r; f_sel = fy_r; end
      4'd2:    begin acc_sel = az_r; f_sel = fz_r; end
      default: begin acc_sel = ax_r; f_sel = fx_r; end
    endcase
    diff_a = {{2{acc_sel[22]}}, acc_sel, 8'b0} - {f_sel[31], f_sel};
    unique case (step_r)
      4'd0, 4'd1, 4'd2: begin mul_a = diff_a; mul_b = {17'b0, gain_r}; end
      4'd3:    begin mul_a = {fx_r[31], fx_r}; mul_b = {fx_r[31], fx_r}; end
      4'd4:    begin mul_a = {fy_r[31], fy_r}; mul_b = {fy_r[31], fy_r}; end
      4'd5:    begin mul_a = {fz_r[31], fz_r}; mul_b = {fz_r[31], fz_r}; end
      4'd6: begin
        mul_a = {9'b0, stand_mag_r, 8'b0};
        mul_b = {9'b0, stand_mag_r, 8'b0};
      end
      4'd7: begin
        mul_a = {9'b0, tilt_mag_r, 8'b0};
        mul_b = {9'b0, tilt_mag_r, 8'b0};
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // rounded filter step from the previous product
  logic signed [65:0] rnd_sum;
  logic signed [31:0] f_step;

  always_comb begin
    rnd_sum = prod_r + 66'sd32768 - {65'b0, prod_r[65]};
    f_step  = rnd_sum[47:16];
  end

  // CORDIC stage
  logic signed [35:0] cx_r, cy_r, px, py, dx, dy;
  logic signed [20:0] cang_r, base;
  logic [3:0]         citer_r;
  logic signed [31:0] y_sel;
  logic signed [20:0] at;

  always_comb begin
    y_sel = pass_r ? fx_r : fy_r;
    px    = {{4{fz_r[31]}}, fz_r};
    py    = {{4{y_sel[31]}}, y_sel};
    base  = '0;
    if (fz_r[31]) begin
      base = (y_sel[31]) ? -tfc_pkg::PI_Q16 : tfc_pkg::PI_Q16;
      px   = -px;
      py   = -py;
    end
    dx = cy_r >>> citer_r;
    dy = cx_r >>> citer_r;
    at = {5'b0, tfc_pkg::atan_q16(citer_r)};
  end

  // rounding, negation and saturation of the angle
  logic signed [17:0] ang_rnd;
  logic signed [21:0] ang_tmp;
  logic signed [18:0] ang_neg;
  logic signed [15:0] ang_out;

  always_comb begin
    ang_tmp = {cang_r[20], cang_r} + 22'sd4 - {21'b0, cang_r[20]};
    ang_rnd = 18'(ang_tmp >>> tfc_pkg::ANGLE_SHIFT);
    ang_neg = -{ang_rnd[17], ang_rnd};
    if (ang_neg > 19'sd32767)       ang_out = 16'sh7fff;
    else if (ang_neg < -19'sd32768) ang_out = 16'sh8000;
    else                            ang_out = ang_neg[15:0];
  end

  logic signed [15:0] roll_r, pitch_r;
  logic [2:0]         posture_r;
  logic [31:0]        fall_t_r;

  // classification
  logic [2:0]         pos_nxt;
  logic signed [16:0] aroll, apitch, fa, la, rl, pt;
  logic [31:0]        elapsed;

  always_comb begin
    rl      = {roll_r[15], roll_r};
    pt      = {pitch_r[15], pitch_r};
    aroll   = rl[16] ? -rl : rl;
    apitch  = pt[16] ? -pt : pt;
    fa      = {2'b0, fall_ang_r};
    la      = {2'b0, lie_ang_r};
    elapsed = now_r - fall_t_r;
    pos_nxt = posture_r;
    if (elapsed > {16'b0, hold_r}) pos_nxt = tfc_pkg::POS_STANDING;
    if (hi_r) begin
      if (aroll > fa && aroll > apitch)
        pos_nxt = (aroll > la) ? tfc_pkg::POS_LIE_SIDE : tfc_pkg::POS_FALL_SIDE;
      if (pt > fa)
        pos_nxt = (pt > la) ? tfc_pkg::POS_LIE_BACK : tfc_pkg::POS_FALL_BACK;
      if (pt < -fa)
        pos_nxt = (pt < -la) ? tfc_pkg::POS_LIE_FRONT : tfc_pkg::POS_FALL_FRONT;
    end
  end

  // up vector: round off the extra filter bits and saturate
  function automatic logic [22:0] up_field(input logic signed [31:0] f);
    logic signed [32:0] s;
    logic signed [24:0] r;
    s = {f[31], f} + 33'sd128 - {32'b0, f[31]};
    r = 25'(s >>> tfc_pkg::FILT_EXTRA);
    if (r > 25'sd4194303)       return 23'h3fffff;
    else if (r < -25'sd4194304) return 23'h400000;
    else                        return r[22:0];
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tfc_pkg::ST_IDLE:  if (in_xfer) state_nxt = tfc_pkg::ST_ARITH;
      tfc_pkg::ST_ARITH: if (step_r == 4'd8) state_nxt = tfc_pkg::ST_CPREP;
      tfc_pkg::ST_CPREP: state_nxt = (py == '0) ? tfc_pkg::ST_CDONE : tfc_pkg::ST_CITER;
      tfc_pkg::ST_CITER: if (citer_r == 4'(tfc_pkg::CORDIC_STEPS - 1))
                           state_nxt = tfc_pkg::ST_CDONE;
      tfc_pkg::ST_CDONE: state_nxt = pass_r ? tfc_pkg::ST_CLASS : tfc_pkg::ST_CPREP;
      tfc_pkg::ST_CLASS: if (out_free) state_nxt = tfc_pkg::ST_IDLE;
      default:           state_nxt = tfc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tfc_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r       <= '0;
      fy_r       <= '0;
      fz_r       <= '0;
      posture_r  <= tfc_pkg::POS_STANDING;
      fall_t_r   <= '0;
      out_tvalid <= 1'b0;
      step_r     <= '0;
      pass_r     <= 1'b0;
      citer_r    <= '0;
    end else begin
      if (out_tvalid && out_tready && state_r != tfc_pkg::ST_CLASS) out_tvalid <= 1'b0;
      unique case (state_r)
        tfc_pkg::ST_IDLE: begin
          if (in_xfer) begin
            ax_r   <= sx;
            ay_r   <= sy;
            az_r   <= sz;
            now_r  <= in_tdata[103:72];
            step_r <= '0;
            pass_r <= 1'b0;
          end
        end
        tfc_pkg::ST_ARITH: begin
          prod_r <= mul_a * mul_b;
          step_r <= step_r + 4'd1;
          unique case (step_r)
            4'd1:    fx_r  <= fx_r + f_step;
            4'd2:    fy_r  <= fy_r + f_step;
            4'd3:    fz_r  <= fz_r + f_step;
            4'd4:    mag_r <= prod_r[63:0];
            4'd5:    mag_r <= mag_r + prod_r[63:0];
            4'd6:    mag_r <= mag_r + prod_r[63:0];
            4'd7:    low_r <= mag_r < prod_r[63:0];
            4'd8:    hi_r  <= mag_r > prod_r[63:0];
            default: ;
          endcase
        end
        tfc_pkg::ST_CPREP: begin
          cx_r    <= px;
          cy_r    <= py;
          cang_r  <= base;
          citer_r <= '0;
        end
        tfc_pkg::ST_CITER: begin
          citer_r <= citer_r + 4'd1;
          if (cy_r > 0) begin
            cx_r   <= cx_r + dx;
            cy_r   <= cy_r - dy;
            cang_r <= cang_r + at;
          end else begin
            cx_r   <= cx_r - dx;
            cy_r   <= cy_r + dy;
            cang_r <= cang_r - at;
          end
        end
        tfc_pkg::ST_CDONE: begin
          if (pass_r) pitch_r <= ang_out;
          else        roll_r  <= ang_out;
          pass_r <= 1'b1;
        end
        tfc_pkg::ST_CLASS: begin
          if (out_free) begin
            out_tvalid <= 1'b1;
            if (low_r) begin
              posture_r <= tfc_pkg::POS_STANDING;
              out_tdata[35:0] <= '0;
            end else begin
              posture_r <= pos_nxt;
              if (pos_nxt != tfc_pkg::POS_STANDING &&
                  posture_r == tfc_pkg::POS_STANDING)
                fall_t_r <= now_r;
              out_tdata[2:0]   <= pos_nxt;
              out_tdata[3]     <= (pos_nxt != tfc_pkg::POS_STANDING);
              out_tdata[19:4]  <= roll_r;
              out_tdata[35:20] <= pitch_r;
            end
            out_tdata[58:36]  <= up_field(fx_r);
            out_tdata[81:59]  <= up_field(fy_r);
            out_tdata[104:82] <= up_field(fz_r);
            out_tdata[111:105] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: bench/tfc_checker.sv
`timescale 1ns / 100ps

module tfc_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [103:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [111:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  output int           fail_count,
  output int           pending,
  output int           result_count
);

  // members listed from the highest bit down
  typedef struct packed {
    logic signed [22:0] up_z;
    logic signed [22:0] up_y;
    logic signed [22:0] up_x;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic               fallen;
    logic [2:0]         orientation;
  } posture_result_t;

  posture_result_t expected_results[$];

  // register copies
  logic [15:0] gain_q, stand_mag_q, tilt_mag_q, hold_ms_q;
  logic [14:0] fall_ang_q, lie_ang_q;
  // filter and posture state
  int                filt_x, filt_y, filt_z;
  tfc_pkg::posture_t cur_posture;
  logic [31:0]       fall_time_q;

  function automatic longint round_near(longint v, int s);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r = (mag + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // cordic vectoring, angle in Q.16
  function automatic longint cordic_atan2(longint y, longint x);
    longint base;
    longint ang;
    longint dx;
    longint dy;
    base = 0;
    ang = 0;
    if (x < 0) begin
      base = (y >= 0) ? longint'(tfc_pkg::PI_Q16) : -longint'(tfc_pkg::PI_Q16);
      x = -x;
      y = -y;
    end
    if (y == 0) return base;
    for (int i = 0; i < tfc_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; ang += longint'(tfc_pkg::atan_q16(4'(i)));
      end else begin
        x -= dx; y += dy; ang -= longint'(tfc_pkg::atan_q16(4'(i)));
      end
    end
    return base + ang;
  endfunction

  function automatic longint tilt_angle(longint y, longint x);
    return clamp(-round_near(cordic_atan2(y, x), tfc_pkg::ANGLE_SHIFT), -32768, 32767);
  endfunction

  function automatic int smooth(int f, longint acc);
    longint diff;
    diff = acc * 256 - longint'(f);
    return int'(longint'(f) + round_near(diff * longint'(gain_q), 16));
  endfunction

  function automatic longint axis_in(logic [22:0] raw, logic bad, logic flip);
    longint v;
    longint lim;
    v = longint'($signed(raw));
    if (flip) v = -v;
    lim = longint'(tfc_pkg::ACC_LIMIT_INT) <<< tfc_pkg::ACC_FRAC_BITS;
    if (bad || v <= -lim || v >= lim) v = 0;
    return v;
  endfunction

  function automatic logic [22:0] up_field(int f);
    return 23'(clamp(round_near(longint'(f), tfc_pkg::FILT_EXTRA), -4194304, 4194303));
  endfunction

  task automatic predict_sample(input logic [103:0] d);
    posture_result_t r;
    longint fx, fy, fz, roll, pitch, aroll, apitch, t, fa, la;
    longint unsigned mag2, thr;
    logic [31:0] now;
    tfc_pkg::posture_t prev;
    now = d[103:72];
    filt_x = smooth(filt_x, axis_in(d[22:0], d[69], 1'b1));
    filt_y = smooth(filt_y, axis_in(d[45:23], d[70], 1'b1));
    filt_z = smooth(filt_z, axis_in(d[68:46], d[71], 1'b0));
    fx = filt_x; fy = filt_y; fz = filt_z;
    mag2 = longint'(fx * fx) + longint'(fy * fy) + longint'(fz * fz);
    roll = 0;
    pitch = 0;
    t = longint'(stand_mag_q) <<< tfc_pkg::FILT_EXTRA;
    thr = t * t;
    if (mag2 < thr) begin
      cur_posture = tfc_pkg::POS_STANDING;
    end else begin
      prev = cur_posture;
      fa = fall_ang_q;
      la = lie_ang_q;
      roll = tilt_angle(fy, fz);
      pitch = tilt_angle(fx, fz);
      if ((now - fall_time_q) > 32'(hold_ms_q)) cur_posture = tfc_pkg::POS_STANDING;
      t = longint'(tilt_mag_q) <<< tfc_pkg::FILT_EXTRA;
      thr = t * t;
      if (mag2 > thr) begin
        apitch = (pitch < 0) ? -pitch : pitch;
        aroll = (roll < 0) ? -roll : roll;
        if (aroll > fa && aroll > apitch)
          cur_posture = (aroll > la) ? tfc_pkg::POS_LIE_SIDE : tfc_pkg::POS_FALL_SIDE;
        if (pitch > fa)
          cur_posture = (pitch > la) ? tfc_pkg::POS_LIE_BACK : tfc_pkg::POS_FALL_BACK;
        if (pitch < -fa)
          cur_posture = (pitch < -la) ? tfc_pkg::POS_LIE_FRONT : tfc_pkg::POS_FALL_FRONT;
      end
      if (cur_posture != tfc_pkg::POS_STANDING && prev == tfc_pkg::POS_STANDING)
        fall_time_q = now;
    end
    r.orientation = cur_posture;
    r.fallen = (cur_posture != tfc_pkg::POS_STANDING);
    r.roll_angle = 16'(roll);
    r.pitch_angle = 16'(pitch);
    r.up_x = up_field(filt_x);
    r.up_y = up_field(filt_y);
    r.up_z = up_field(filt_z);
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    posture_result_t e;
    posture_result_t a;
    if (!rst_n) begin
      gain_q <= 16'd3277; stand_mag_q <= 16'd1280; tilt_mag_q <= 16'd1536;
      fall_ang_q <= 15'd6554; lie_ang_q <= 15'd9830; hold_ms_q <= 16'd3000;
      filt_x = 0; filt_y = 0; filt_z = 0;
      cur_posture = tfc_pkg::POS_STANDING;
      fall_time_q = '0;
      expected_results.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          tfc_pkg::REG_FILTER_GAIN:  gain_q <= cfg_wdata;
          tfc_pkg::REG_STANDING_MAG: stand_mag_q <= cfg_wdata;
          tfc_pkg::REG_TILT_MAG:     tilt_mag_q <= cfg_wdata;
          tfc_pkg::REG_FALLING_ANG:  fall_ang_q <= cfg_wdata[14:0];
          tfc_pkg::REG_LYING_ANG:    lie_ang_q <= cfg_wdata[14:0];
          tfc_pkg::REG_FALL_HOLD:    hold_ms_q <= cfg_wdata;
          default: ;
        endcase
      end
      // sample transfer
      if (in_tvalid && in_tready) predict_sample(in_tdata);
      // result transfer
      if (out_tvalid && out_tready) begin
        result_count++;
        a = out_tdata[104:0];
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          check_field("orientation", e.orientation, a.orientation);
          check_field("fallen", e.fallen, a.fallen);
          check_field("roll_angle", e.roll_angle, a.roll_angle);
          check_field("pitch_angle", e.pitch_angle, a.pitch_angle);
          check_field("up_x", e.up_x, a.up_x);
          check_field("up_y", e.up_y, a.up_y);
          check_field("up_z", e.up_z, a.up_z);
          check_field("zero fill", 0, out_tdata[111:105]);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // acc_x, acc_y, acc_z, axis_invalid, time_ms
  logic [103:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // orientation, fallen, roll_angle, pitch_angle, up_x, up_y, up_z, zero fill
  logic [111:0] out_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_wdata;

  int          fail_count, pending, result_count;
  logic        quiet;
  logic [31:0] clock_ms;
  int          sent;

  tilt_fall_classifier dut (.*);

  tfc_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run time limit
  initial begin
    #30ms;
    $display("Test completed with failures");
    $finish;
  end

  // result side stalls
  initial begin
    out_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input int ax, input int ay, input int az,
                             input logic [2:0] bad, input logic [31:0] ms);
    in_tdata <= {ms, bad, 23'(az), 23'(ay), 23'(ax)};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] g, input logic [15:0] sm, input logic [15:0] tm,
                          input logic [15:0] fa, input logic [15:0] la, input logic [15:0] h);
    wait_idle();
    write_reg(tfc_pkg::REG_FILTER_GAIN, g);
    write_reg(tfc_pkg::REG_STANDING_MAG, sm);
    write_reg(tfc_pkg::REG_TILT_MAG, tm);
    write_reg(tfc_pkg::REG_FALLING_ANG, fa);
    write_reg(tfc_pkg::REG_LYING_ANG, la);
    write_reg(tfc_pkg::REG_FALL_HOLD, h);
  endtask

  function automatic int rand_axis(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // mostly plausible gravity vectors, some noise and broken readings
  task automatic random_sample();
    int ax, ay, az, sel;
    logic [2:0] bad;
    sel = $urandom_range(0, 99);
    bad = 3'b000;
    if (sel < 65) begin
      case ($urandom_range(0, 4))
        0: begin ax = rand_axis(400); ay = rand_axis(400); az = 2511 + rand_axis(300); end
        1: begin ax = rand_axis(2600); ay = rand_axis(400); az = rand_axis(2600); end
        2: begin ax = rand_axis(400); ay = rand_axis(2600); az = rand_axis(2600); end
        3: begin ax = rand_axis(300); ay = rand_axis(300); az = rand_axis(300); end
        default: begin ax = rand_axis(4000); ay = rand_axis(4000); az = rand_axis(4000); end
      endcase
    end else begin
      ax = rand_axis(2560000); ay = rand_axis(2560000); az = rand_axis(2560000);
      if (sel < 80) bad = 3'($urandom_range(0, 7));
    end
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 700);
    send_sample(ax, ay, az, bad, clock_ms);
  endtask

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    sent = 0;
    clock_ms = 32'hFFFF_F000;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero vector, limits, invalid flags, negative z, hold wrap
    send_sample(0, 0, 0, 3'b000, 32'd0);
    set_regs(16'd65535, 16'd0, 16'd0, 16'd6554, 16'd9830, 16'd0);
    write_reg(3'd6, 16'd1);
    write_reg(3'd7, 16'hFFFF);
    send_sample(0, 0, 0, 3'b000, 32'd1);
    send_sample(0, 0, -2511, 3'b000, 32'd2);
    send_sample(0, 0, 2511, 3'b000, 32'd3);
    send_sample(2559999, -2559999, 2559999, 3'b000, 32'd4);
    send_sample(-2559999, 2559999, -2559999, 3'b000, 32'd5);
    send_sample(2560000, -2560000, 2560000, 3'b000, 32'd6);
    send_sample(-2560000, 2560000, -2560000, 3'b000, 32'd7);
    send_sample(2000, 2000, 2000, 3'b111, 32'd8);
    send_sample(2500, 0, 300, 3'b000, 32'd9);
    send_sample(-2500, 0, 300, 3'b000, 32'd10);
    send_sample(0, 2500, 300, 3'b000, 32'd11);
    send_sample(0, -2500, 300, 3'b001, 32'd12);
    send_sample(1500, 0, -2000, 3'b010, 32'hFFFF_FFFF);
    send_sample(0, 0, 2511, 3'b100, 32'd0);
    send_sample(-4194304, 4194303, 0, 3'b000, 32'h8000_0000);

    // random phases over several register settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_regs(16'd3277, 16'd1280, 16'd1536, 16'd6554, 16'd9830, 16'd3000);
        1: set_regs(16'd65535, 16'd1280, 16'd1536, 16'hFFFF, 16'd9830, 16'd200);
        2: set_regs(16'd32768, 16'd0, 16'd65535, 16'd0, 16'd25736, 16'd65535);
        3: set_regs(16'd1, 16'd65535, 16'd0, 16'd25736, 16'd0, 16'd0);
        4: set_regs(16'd0, 16'd500, 16'd600, 16'd3000, 16'hFFFF, 16'd1000);
        5: set_regs(16'd40000, 16'd800, 16'd1000, 16'd4000, 16'd8000, 16'd300);
        default: set_regs(16'd60000, 16'd1280, 16'd1536, 16'd6554, 16'd9830, 16'd1500);
      endcase
      if (ph == 6) quiet = 1'b1;
      repeat (190) random_sample();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d samples over 8 register settings, checked %0d results",
             sent, result_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tfc_pkg.sv
rtl/tilt_fall_classifier.sv
bench/tfc_checker.sv
bench/testbench.sv
